@@ src/rtes_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC snapshot decoder package
// Shared widths, constants, payload structs and the divide-by-100 helper used
// by the decode, day count and seconds stages.
// ----------------------------------------------------------------------------
package rtes_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned CY_W          = 12;
  localparam int unsigned YEAR_W        = 13;
  localparam int unsigned Q100_W        = 7;
  localparam int unsigned DAYS_W        = 20;
  localparam int unsigned CUM_W         = 9;
  localparam int unsigned SECS_W        = 32;

  // Status B and hour register bit positions.
  localparam int unsigned STAT_BIN_BIT  = 2;
  localparam int unsigned STAT_24H_BIT  = 1;
  localparam int unsigned HOUR_PM_BIT   = 7;

  localparam int unsigned CY_RESET      = 2015;
  localparam int unsigned BASE_RESET    = 2000;
  localparam int unsigned EPOCH_YEAR    = 1970;
  localparam int unsigned LEAPS_1969    = 477;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned CENTURY       = 100;
  localparam int unsigned MONTHS        = 12;
  localparam int unsigned MONTH_FEB     = 2;

  // floor(v / 100) = (v * 5243) >> 19 for every v below 2^13.
  localparam int unsigned DIV100_MUL    = 5243;
  localparam int unsigned DIV100_MUL_W  = 13;
  localparam int unsigned DIV100_SHIFT  = 19;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CY_W-1:0]   cy_t;
  typedef logic [YEAR_W-1:0] year_t;
  typedef logic [Q100_W-1:0] q100_t;
  typedef logic [DAYS_W-1:0] days_t;
  typedef logic [CUM_W-1:0]  cum_t;
  typedef logic [SECS_W-1:0] secs_t;

  typedef struct packed {
    byte_t second;
    byte_t minute;
    byte_t hour;
    byte_t day;
    byte_t month;
    byte_t year2;
    byte_t flags;
  } raw_snap_t;

  typedef struct packed {
    byte_t second;
    byte_t minute;
    byte_t hour;
    byte_t day;
    byte_t month;
    year_t year;
    logic  bad;
  } time_fields_t;

  typedef struct packed {
    time_fields_t t;
    days_t        days;
  } day_fields_t;

  typedef struct packed {
    byte_t second;
    byte_t minute;
    byte_t hour;
    byte_t day;
    byte_t month;
    cy_t   full_year;
    secs_t elapsed_seconds;
    logic  invalid;
  } result_t;

  function automatic q100_t div100(input year_t v);
    logic [YEAR_W+DIV100_MUL_W-1:0] prod;
    prod = (YEAR_W+DIV100_MUL_W)'(v) * (YEAR_W+DIV100_MUL_W)'(DIV100_MUL);
    return prod[DIV100_SHIFT +: Q100_W];
  endfunction

endpackage

@@ src/rtes_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC snapshot field decoder
// Converts BCD or binary bytes, folds 12-hour time into 24-hour form and
// places the two-digit year in the configured century window. Registered.
// ----------------------------------------------------------------------------
module rtes_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtes_pkg::raw_snap_t   snap_i,
  input  logic                  snap_vld_i,
  input  rtes_pkg::cy_t         cur_year_i,
  input  rtes_pkg::cy_t         base_year_i,
  output rtes_pkg::time_fields_t fields_o,
  output logic                  fields_vld_o
);
  import rtes_pkg::*;

  time_fields_t fields_r, fields_nxt;
  logic         vld_r;

  function automatic byte_t from_bcd(input byte_t v);
    return byte_t'(v[3:0]) + byte_t'({v[7:4], 3'b000}) + byte_t'({v[7:4], 1'b0});
  endfunction

  // Input is below 140, so three restoring steps give the remainder.
  function automatic byte_t mod24(input byte_t v);
    byte_t r;
    r = v;
    if (r >= byte_t'(96)) r = r - byte_t'(96);
    if (r >= byte_t'(48)) r = r - byte_t'(48);
    if (r >= byte_t'(24)) r = r - byte_t'(24);
    return r;
  endfunction

  byte_t sec_d, min_d, hour_d, day_d, mon_d, yr2_d, hour_h;
  year_t year_sum;

  always_comb begin
    if (snap_i.flags[STAT_BIN_BIT]) begin
      sec_d  = snap_i.second;
      min_d  = snap_i.minute;
      hour_d = snap_i.hour;
      day_d  = snap_i.day;
      mon_d  = snap_i.month;
      yr2_d  = snap_i.year2;
    end else begin
      sec_d  = from_bcd(snap_i.second);
      min_d  = from_bcd(snap_i.minute);
      hour_d = byte_t'(snap_i.hour[3:0]) + byte_t'({snap_i.hour[6:4], 3'b000})
             + byte_t'({snap_i.hour[6:4], 1'b0}) + {snap_i.hour[7], 7'b0};
      day_d  = from_bcd(snap_i.day);
      mon_d  = from_bcd(snap_i.month);
      yr2_d  = from_bcd(snap_i.year2);
    end

    hour_h = {1'b0, hour_d[6:0]};
    if (!snap_i.flags[STAT_24H_BIT]) begin
      if (hour_h == byte_t'(12)) hour_h = '0;
      if (hour_d[HOUR_PM_BIT]) hour_h = mod24(hour_h + byte_t'(12));
    end else begin
      hour_h = hour_d;
    end

    year_sum = year_t'(yr2_d) + year_t'(base_year_i);

    fields_nxt.second = sec_d;
    fields_nxt.minute = min_d;
    fields_nxt.hour   = hour_h;
    fields_nxt.day    = day_d;
    fields_nxt.month  = mon_d;
    fields_nxt.year   = (year_sum < year_t'(cur_year_i)) ?
                        year_sum + year_t'(CENTURY) : year_sum;
    fields_nxt.bad    = (mon_d == '0) || (mon_d > byte_t'(MONTHS)) || (day_d == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= snap_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    fields_r <= fields_nxt;
  end

  assign fields_o     = fields_r;
  assign fields_vld_o = vld_r;

endmodule

@@ src/rtes_days.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Day counter
// Two registered steps: year quotients by 100, then days since 1970-01-01.
// ----------------------------------------------------------------------------
module rtes_days (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rtes_pkg::time_fields_t fields_i,
  input  logic                   fields_vld_i,
  output rtes_pkg::day_fields_t  days_o,
  output logic                   days_vld_o
);
  import rtes_pkg::*;

  time_fields_t q_fields_r;
  q100_t        q_cur_r, q_prev_r;
  logic         q_vld_r;
  day_fields_t  days_r, days_nxt;
  logic         days_vld_r;

  function automatic cum_t cum_days(input logic [3:0] m);
    cum_t c;
    case (m)
      4'd2:    c = cum_t'(31);
      4'd3:    c = cum_t'(59);
      4'd4:    c = cum_t'(90);
      4'd5:    c = cum_t'(120);
      4'd6:    c = cum_t'(151);
      4'd7:    c = cum_t'(181);
      4'd8:    c = cum_t'(212);
      4'd9:    c = cum_t'(243);
      4'd10:   c = cum_t'(273);
      4'd11:   c = cum_t'(304);
      4'd12:   c = cum_t'(334);
      default: c = '0;
    endcase
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r    <= 1'b0;
      days_vld_r <= 1'b0;
    end else begin
      q_vld_r    <= fields_vld_i;
      days_vld_r <= q_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    q_fields_r <= fields_i;
    q_cur_r    <= div100(fields_i.year);
    q_prev_r   <= div100(fields_i.year - year_t'(1));
  end

  year_t y;
  year_t y_prev;
  year_t cent;
  logic  leap;
  days_t leaps;
  days_t span;

  always_comb begin
    y      = q_fields_r.year;
    y_prev = y - year_t'(1);
    cent   = year_t'(q_cur_r) * year_t'(CENTURY);
    leap   = ((y[1:0] == 2'b00) && (cent != y)) || ((cent == y) && (q_cur_r[1:0] == 2'b00));
    leaps  = days_t'(y_prev[YEAR_W-1:2]) - days_t'(q_prev_r) + days_t'(q_prev_r[Q100_W-1:2]);
    span   = '0;
    if (y > year_t'(EPOCH_YEAR)) begin
      span = days_t'(y - year_t'(EPOCH_YEAR)) * days_t'(DAYS_PER_YEAR)
           + leaps - days_t'(LEAPS_1969);
    end
    days_nxt.t    = q_fields_r;
    days_nxt.days = span + days_t'(cum_days(q_fields_r.month[3:0]))
                  + days_t'(leap && (q_fields_r.month > byte_t'(MONTH_FEB)))
                  + days_t'(q_fields_r.day) - days_t'(1);
  end

  always_ff @(posedge clk) begin
    days_r <= days_nxt;
  end

  assign days_o     = days_r;
  assign days_vld_o = days_vld_r;

endmodule

@@ src/rtes_secs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seconds assembler
// Scales the day count and time of day to seconds and registers the result.
// ----------------------------------------------------------------------------
module rtes_secs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtes_pkg::day_fields_t days_i,
  input  logic                  days_vld_i,
  output rtes_pkg::result_t     result_o,
  output logic                  result_vld_o
);
  import rtes_pkg::*;

  result_t result_r, result_nxt;
  logic    vld_r;
  secs_t   secs;

  always_comb begin
    secs = secs_t'(days_i.days) * secs_t'(SECS_PER_DAY)
         + secs_t'(days_i.t.hour) * secs_t'(SECS_PER_HOUR)
         + secs_t'(days_i.t.minute) * secs_t'(SECS_PER_MIN)
         + secs_t'(days_i.t.second);
    result_nxt.second          = days_i.t.second;
    result_nxt.minute          = days_i.t.minute;
    result_nxt.hour            = days_i.t.hour;
    result_nxt.day             = days_i.t.day;
    result_nxt.month           = days_i.t.month;
    result_nxt.full_year       = days_i.t.year[CY_W-1:0];
    result_nxt.elapsed_seconds = days_i.t.bad ? '0 : secs;
    result_nxt.invalid         = days_i.t.bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= days_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign result_o     = result_r;
  assign result_vld_o = vld_r;

endmodule

@@ src/rtc_time_to_epoch_seconds.sv @@
`timescale 1ns / 1ps
// A taken word passes through the input register, decode, quotients, days and seconds
// registers before its out_valid strobe.
// Throughput: one word per cycle; busy is always low and the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the pipeline and sets the first year to 2015.
// ----------------------------------------------------------------------------
// RTC snapshot to epoch seconds converter
// Decodes a raw RTC register snapshot into calendar fields, a four-digit year
// and seconds since 1970-01-01 00:00, modulo 2^32.
// ----------------------------------------------------------------------------
module rtc_time_to_epoch_seconds (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rtes_pkg::byte_t     in_raw_second,
  input  rtes_pkg::byte_t     in_raw_minute,
  input  rtes_pkg::byte_t     in_raw_hour,
  input  rtes_pkg::byte_t     in_raw_day,
  input  rtes_pkg::byte_t     in_raw_month,
  input  rtes_pkg::byte_t     in_raw_year,
  input  rtes_pkg::byte_t     in_status_flags,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  rtes_pkg::cy_t       cfg_first_year,
  output logic                out_valid,
  output rtes_pkg::byte_t     out_second,
  output rtes_pkg::byte_t     out_minute,
  output rtes_pkg::byte_t     out_hour,
  output rtes_pkg::byte_t     out_day,
  output rtes_pkg::byte_t     out_month,
  output rtes_pkg::cy_t       out_full_year,
  output rtes_pkg::secs_t     out_elapsed_seconds,
  output logic                out_invalid
);
  import rtes_pkg::*;

  // The pipeline never holds a word back, so a word is taken on every start.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic accept;
  assign accept = start && !busy;

  // Configuration: the window start year and its century base. The base is
  // computed once per write so the per-word path only needs an add.
  cy_t   cy_r, cy_nxt;
  cy_t   base_r, base_nxt;
  q100_t cfg_q;

  always_comb begin
    cfg_q    = div100(year_t'(cfg_first_year));
    cy_nxt   = cy_r;
    base_nxt = base_r;
    if (cfg_valid && cfg_ready) begin
      cy_nxt   = cfg_first_year;
      base_nxt = cy_t'(cfg_q) * cy_t'(CENTURY);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cy_r   <= cy_t'(CY_RESET);
      base_r <= cy_t'(BASE_RESET);
    end else begin
      cy_r   <= cy_nxt;
      base_r <= base_nxt;
    end
  end

  // Input register: the snapshot is captured on acceptance.
  raw_snap_t snap_r;
  logic      snap_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_vld_r <= 1'b0;
    end else begin
      snap_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      snap_r.second <= in_raw_second;
      snap_r.minute <= in_raw_minute;
      snap_r.hour   <= in_raw_hour;
      snap_r.day    <= in_raw_day;
      snap_r.month  <= in_raw_month;
      snap_r.year2  <= in_raw_year;
      snap_r.flags  <= in_status_flags;
    end
  end

  time_fields_t fields;
  logic         fields_vld;
  day_fields_t  days;
  logic         days_vld;
  result_t      result;
  logic         result_vld;

  rtes_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .snap_i       (snap_r),
    .snap_vld_i   (snap_vld_r),
    .cur_year_i   (cy_r),
    .base_year_i  (base_r),
    .fields_o     (fields),
    .fields_vld_o (fields_vld)
  );

  rtes_days u_days (
    .clk          (clk),
    .rst_n        (rst_n),
    .fields_i     (fields),
    .fields_vld_i (fields_vld),
    .days_o       (days),
    .days_vld_o   (days_vld)
  );

  rtes_secs u_secs (
    .clk          (clk),
    .rst_n        (rst_n),
    .days_i       (days),
    .days_vld_i   (days_vld),
    .result_o     (result),
    .result_vld_o (result_vld)
  );

  // Results leave straight from the output register of the seconds stage.
  assign out_valid           = result_vld;
  assign out_second          = result.second;
  assign out_minute          = result.minute;
  assign out_hour            = result.hour;
  assign out_day             = result.day;
  assign out_month           = result.month;
  assign out_full_year       = result.full_year;
  assign out_elapsed_seconds = result.elapsed_seconds;
  assign out_invalid         = result.invalid;

  // Every result traces back to an accepted word.
  a_result_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 5))
    else $error("result strobe without an accepted word");

  // An invalid date never carries a seconds count.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid) |-> (out_elapsed_seconds == '0))
    else $error("invalid date with nonzero seconds");

  // A valid result has a real month and a nonzero day.
  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_invalid) |->
      ((out_month != '0) && (out_month <= byte_t'(MONTHS)) && (out_day != '0)))
    else $error("valid flag on an out-of-range date");

  // The century base always sits within one century at or below the window start.
  a_base_window: assert property (@(posedge clk) disable iff (!rst_n)
    (base_r <= cy_r) && ((cy_r - base_r) < cy_t'(CENTURY)))
    else $error("century base out of step with current year");

endmodule

@@ test/rtc_epoch_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC epoch converter checker
// Watches the snapshot, configuration and result channels, predicts each
// result from the accepted snapshot and the current year, and compares.
// ----------------------------------------------------------------------------
module rtc_epoch_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  rtes_pkg::byte_t in_raw_second,
  input  rtes_pkg::byte_t in_raw_minute,
  input  rtes_pkg::byte_t in_raw_hour,
  input  rtes_pkg::byte_t in_raw_day,
  input  rtes_pkg::byte_t in_raw_month,
  input  rtes_pkg::byte_t in_raw_year,
  input  rtes_pkg::byte_t in_status_flags,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  rtes_pkg::cy_t   cfg_first_year,
  input  logic            out_valid,
  input  rtes_pkg::byte_t out_second,
  input  rtes_pkg::byte_t out_minute,
  input  rtes_pkg::byte_t out_hour,
  input  rtes_pkg::byte_t out_day,
  input  rtes_pkg::byte_t out_month,
  input  rtes_pkg::cy_t   out_full_year,
  input  rtes_pkg::secs_t out_elapsed_seconds,
  input  logic            out_invalid,
  output int unsigned     error_count,
  output int unsigned     words_in_flight
);
  import rtes_pkg::*;

  result_t     expected_results[$];
  cy_t         year_setting;
  int unsigned fail_total = 0;

  function automatic int unsigned bcd_value(input byte_t v);
    return int'(v[3:0]) + int'(v[7:4]) * 10;
  endfunction

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Leap years in 1..y.
  function automatic int unsigned leaps_through(input int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic int unsigned month_length(input int unsigned m);
    case (m)
      2:           return 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic result_t decode_snapshot(input raw_snap_t s, input cy_t cy);
    result_t     r;
    int unsigned sec, mnt, hr, day, mon, yr2, year, days, secs, h, m;
    logic        bad;
    sec = 32'(s.second);
    mnt = 32'(s.minute);
    hr  = 32'(s.hour);
    day = 32'(s.day);
    mon = 32'(s.month);
    yr2 = 32'(s.year2);
    if (!s.flags[STAT_BIN_BIT]) begin
      sec = bcd_value(s.second);
      mnt = bcd_value(s.minute);
      hr  = int'(s.hour[3:0]) + int'(s.hour[6:4]) * 10 + (s.hour[HOUR_PM_BIT] ? 128 : 0);
      day = bcd_value(s.day);
      mon = bcd_value(s.month);
      yr2 = bcd_value(s.year2);
    end
    if (!s.flags[STAT_24H_BIT]) begin
      h = hr & 32'h7F;
      if (h == 12) h = 0;
      if ((hr & 32'h80) != 0) h = (h + 12) % 24;
      hr = h;
    end
    year = yr2 + (int'(cy) / CENTURY) * CENTURY;
    if (year < 32'(cy)) year += CENTURY;
    bad  = (mon < 1) || (mon > MONTHS) || (day == 0);
    secs = 0;
    if (!bad) begin
      days = 0;
      if (year > EPOCH_YEAR)
        days = DAYS_PER_YEAR * (year - EPOCH_YEAR) + leaps_through(year - 1)
               - leaps_through(EPOCH_YEAR - 1);
      for (m = 1; m < mon; m++) begin
        days += month_length(m);
        if (m == MONTH_FEB && leap_year(year)) days += 1;
      end
      days += day - 1;
      // 32-bit unsigned arithmetic wraps exactly as the block does.
      secs = days * SECS_PER_DAY + hr * SECS_PER_HOUR + mnt * SECS_PER_MIN + sec;
    end
    r.second          = byte_t'(sec);
    r.minute          = byte_t'(mnt);
    r.hour            = byte_t'(hr);
    r.day             = byte_t'(day);
    r.month           = byte_t'(mon);
    r.full_year       = cy_t'(year);
    r.elapsed_seconds = secs;
    r.invalid         = bad;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    result_t   want;
    raw_snap_t snap;
    if (!rst_n) begin
      expected_results.delete();
      year_setting = cy_t'(CY_RESET);
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("out_valid: result word with no expected word waiting");
          fail_total++;
        end else begin
          want = expected_results.pop_front();
          compare_field("out_second", 32'(want.second), 32'(out_second));
          compare_field("out_minute", 32'(want.minute), 32'(out_minute));
          compare_field("out_hour", 32'(want.hour), 32'(out_hour));
          compare_field("out_day", 32'(want.day), 32'(out_day));
          compare_field("out_month", 32'(want.month), 32'(out_month));
          compare_field("out_full_year", 32'(want.full_year), 32'(out_full_year));
          compare_field("out_elapsed_seconds", want.elapsed_seconds, out_elapsed_seconds);
          compare_field("out_invalid", 32'(want.invalid), 32'(out_invalid));
        end
      end
      if (start && !busy) begin
        snap = '{second: in_raw_second, minute: in_raw_minute, hour: in_raw_hour,
                 day: in_raw_day, month: in_raw_month, year2: in_raw_year,
                 flags: in_status_flags};
        expected_results.push_back(decode_snapshot(snap, year_setting));
      end
      if (cfg_valid && cfg_ready) year_setting = cfg_first_year;
    end
    error_count     <= fail_total;
    words_in_flight <= expected_results.size();
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC snapshot to epoch seconds converter testbench
// Drives directed and random RTC snapshots through several current-year
// settings with random sender gaps; a checker beside the block predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module testbench;
  import rtes_pkg::*;

  localparam int unsigned PHASES          = 8;
  localparam int unsigned WORDS_PER_PHASE = 190;
  localparam int unsigned LATENCY_PAUSE   = 8;

  // Status B bits as the snapshot carries them.
  localparam byte_t FLAG_BIN = 8'h04;
  localparam byte_t FLAG_24H = 8'h02;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  byte_t       in_raw_second   = '0;
  byte_t       in_raw_minute   = '0;
  byte_t       in_raw_hour     = '0;
  byte_t       in_raw_day      = '0;
  byte_t       in_raw_month    = '0;
  byte_t       in_raw_year     = '0;
  byte_t       in_status_flags = '0;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  cy_t         cfg_first_year = '0;
  logic        out_valid;
  byte_t       out_second, out_minute, out_hour, out_day, out_month;
  cy_t         out_full_year;
  secs_t       out_elapsed_seconds;
  logic        out_invalid;
  int unsigned error_count;
  int unsigned words_in_flight;

  // The clock period is 2 ns.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rtc_time_to_epoch_seconds i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_raw_second       (in_raw_second),
    .in_raw_minute       (in_raw_minute),
    .in_raw_hour         (in_raw_hour),
    .in_raw_day          (in_raw_day),
    .in_raw_month        (in_raw_month),
    .in_raw_year         (in_raw_year),
    .in_status_flags     (in_status_flags),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_first_year      (cfg_first_year),
    .out_valid           (out_valid),
    .out_second          (out_second),
    .out_minute          (out_minute),
    .out_hour            (out_hour),
    .out_day             (out_day),
    .out_month           (out_month),
    .out_full_year       (out_full_year),
    .out_elapsed_seconds (out_elapsed_seconds),
    .out_invalid         (out_invalid)
  );

  rtc_epoch_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_raw_second       (in_raw_second),
    .in_raw_minute       (in_raw_minute),
    .in_raw_hour         (in_raw_hour),
    .in_raw_day          (in_raw_day),
    .in_raw_month        (in_raw_month),
    .in_raw_year         (in_raw_year),
    .in_status_flags     (in_status_flags),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_first_year      (cfg_first_year),
    .out_valid           (out_valid),
    .out_second          (out_second),
    .out_minute          (out_minute),
    .out_hour            (out_hour),
    .out_day             (out_day),
    .out_month           (out_month),
    .out_full_year       (out_full_year),
    .out_elapsed_seconds (out_elapsed_seconds),
    .out_invalid         (out_invalid),
    .error_count         (error_count),
    .words_in_flight     (words_in_flight)
  );

  function automatic raw_snap_t snap(input byte_t sec, input byte_t mnt, input byte_t hr,
                                     input byte_t day, input byte_t mon, input byte_t yr,
                                     input byte_t flags);
    return '{second: sec, minute: mnt, hour: hr, day: day, month: mon, year2: yr,
             flags: flags};
  endfunction

  // Encodes a value below 100 in the register format that status B selects.
  function automatic byte_t rtc_encode(input int unsigned v, input bit binary);
    return binary ? byte_t'(v) : byte_t'(((v / 10) << 4) | (v % 10));
  endfunction

  // Most random words are plausible clock readings with random flags, so the
  // day count and the hour conversion are exercised in depth. A fifth are
  // raw noise, and a few plausible ones carry a bad month or a zero day.
  function automatic raw_snap_t random_word();
    byte_t       flags;
    bit          binary, h24;
    int unsigned hr, mon, day;
    byte_t       hr_byte;
    flags  = 8'($urandom);
    binary = flags[STAT_BIN_BIT];
    h24    = flags[STAT_24H_BIT];
    if ($urandom_range(99) < 20)
      return snap(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), flags);
    hr      = h24 ? $urandom_range(23) : $urandom_range(12, 1);
    hr_byte = rtc_encode(hr, binary);
    if (!h24 && $urandom_range(1)) hr_byte[HOUR_PM_BIT] = 1'b1;
    mon = ($urandom_range(99) < 5) ? $urandom_range(19) : $urandom_range(12, 1);
    day = ($urandom_range(99) < 5) ? 0 : $urandom_range(31, 1);
    return snap(rtc_encode($urandom_range(59), binary), rtc_encode($urandom_range(59), binary),
                hr_byte, rtc_encode(day, binary), rtc_encode(mon, binary),
                rtc_encode($urandom_range(99), binary), flags);
  endfunction

  // Offers one word, after a random number of idle cycles, and waits until the
  // block takes it. Start stays high when the next word follows at once.
  task automatic send_word(input raw_snap_t w, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_raw_second   <= w.second;
    in_raw_minute   <= w.minute;
    in_raw_hour     <= w.hour;
    in_raw_day      <= w.day;
    in_raw_month    <= w.month;
    in_raw_year     <= w.year2;
    in_status_flags <= w.flags;
    do @(posedge clk); while (busy);
  endtask

  // Stops the sender and lets every expected word come out, then pauses for
  // the pipeline latency so the block is idle.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
    repeat (LATENCY_PAUSE) @(posedge clk);
  endtask

  task automatic write_first_year(input cy_t cy);
    cfg_valid      <= 1'b1;
    cfg_first_year <= cy;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  raw_snap_t   directed_words[$];
  cy_t         phase_years[PHASES];
  int unsigned phase_idle[4] = '{0, 51, 0, 31};

  initial begin
    // Reset is held low from the start and never asserted again.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words run under the reset value of the current year.
    // All zeros: month zero is invalid, hour zero in 12-hour BCD.
    directed_words.push_back(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // All ones: binary, 24-hour, huge hour and an invalid month.
    directed_words.push_back(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // Start of the year window in BCD 24-hour mode.
    directed_words.push_back(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h15, FLAG_24H));
    // Last second of a year in binary 24-hour mode.
    directed_words.push_back(snap(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd99,
                                  FLAG_BIN | FLAG_24H));
    // Midnight and noon in 12-hour BCD, then a late PM hour.
    directed_words.push_back(snap(8'h30, 8'h45, 8'h12, 8'h15, 8'h06, 8'h20, 8'h00));
    directed_words.push_back(snap(8'h00, 8'h00, 8'h92, 8'h15, 8'h06, 8'h20, 8'h00));
    directed_words.push_back(snap(8'h00, 8'h30, 8'h91, 8'h15, 8'h06, 8'h20, 8'h00));
    // Binary 12-hour mode: an AM hour, a PM hour and 12 PM.
    directed_words.push_back(snap(8'd5, 8'd6, 8'd11, 8'd2, 8'd3, 8'd4, FLAG_BIN));
    directed_words.push_back(snap(8'd5, 8'd6, 8'h87, 8'd2, 8'd3, 8'd4, FLAG_BIN));
    directed_words.push_back(snap(8'd5, 8'd6, 8'h8C, 8'd2, 8'd3, 8'd4, FLAG_BIN));
    // BCD bytes whose nibbles are not decimal digits.
    directed_words.push_back(snap(8'hFA, 8'hBC, 8'h7F, 8'h1F, 8'h0A, 8'h9F, 8'h00));
    // Month thirteen and day zero are both invalid.
    directed_words.push_back(snap(8'h10, 8'h20, 8'h08, 8'h05, 8'h13, 8'h21, FLAG_24H));
    directed_words.push_back(snap(8'h10, 8'h20, 8'h08, 8'h00, 8'h05, 8'h21, FLAG_24H));
    // Leap day and the day after it, and a century year that is not leap.
    directed_words.push_back(snap(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h16, FLAG_24H));
    directed_words.push_back(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h16, FLAG_24H));
    directed_words.push_back(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, FLAG_24H));
    // A day beyond the length of its month is simply counted.
    directed_words.push_back(snap(8'h00, 8'h00, 8'h00, 8'h31, 8'h02, 8'h17, FLAG_24H));
    // In 24-hour mode the PM bit passes into the hour unchanged.
    directed_words.push_back(snap(8'h00, 8'h00, 8'h95, 8'h01, 8'h01, 8'h30, FLAG_24H));
    // A far year whose seconds wrap past 32 bits.
    directed_words.push_back(snap(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'hFF,
                                  FLAG_BIN | FLAG_24H));
    // Unused status bits set around a BCD 12-hour reading.
    directed_words.push_back(snap(8'h59, 8'h01, 8'h89, 8'h28, 8'h11, 8'h48, 8'hF9));
    foreach (directed_words[i]) send_word(directed_words[i], 0);

    // Year settings: the register extremes reach years before 1970 and years
    // past 12 bits, plus the ends of the usual range and random ones.
    phase_years = '{cy_t'(0), cy_t'(1969), cy_t'(1970), cy_t'(2099), cy_t'(4095),
                    cy_t'($urandom_range(2099, 1970)), cy_t'($urandom), cy_t'(CY_RESET)};
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_first_year(phase_years[p]);
      for (int n = 0; n < WORDS_PER_PHASE; n++) send_word(random_word(), phase_idle[p % 4]);
    end
    drain_results();

    if (error_count == 0 && words_in_flight == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
